// ===== rtl/tclp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared widths, codes and types for the tile tag store.
// ----------------------------------------------------------------------------
package tclp_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int MAX_ZOOM  = 20;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int SLOT_W    = 6;
  localparam int COORD_W   = 20;
  localparam int ZOOM_W    = 5;
  localparam int STAMP_W   = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;

  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DONE    = 2'd1;

  localparam logic [STATUS_W-1:0] ST_VALID_HIT   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PENDING_HIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COMPLETED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_STALE       = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [ZOOM_W-1:0]  zoom;
  } tag_t;

  typedef struct packed {
    logic               hit;
    logic               hit_valid;
    logic [IDX_W-1:0]   hit_idx;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
    logic               lru;
    logic [IDX_W-1:0]   lru_idx;
    logic [STAMP_W-1:0] lru_stamp;
    logic               lru_valid;
    logic               done_match;
  } scan_t;

  typedef struct packed {
    logic               alloc;
    logic               touch;
    logic               done;
    logic               clear;
    logic [IDX_W-1:0]   idx;
    logic               ok;
    logic [STAMP_W-1:0] stamp;
  } upd_t;

endpackage

// ===== rtl/tclp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_cell
// One tag store entry; folds its entry into the passing scan word.
// ----------------------------------------------------------------------------
module tclp_cell import tclp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx,
  input  tag_t             req_tag,
  input  logic [IDX_W-1:0] sel_idx,
  input  logic             sel_ok,
  input  upd_t             upd,
  input  scan_t            scan_in,
  output scan_t            scan_out
);

  tag_t               tag_r,   tag_nxt;
  logic               valid_r, valid_nxt;
  logic               pend_r,  pend_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  scan_t              scan_r,  scan_nxt;
  logic               match;
  logic               mine;

  assign match = (tag_r == req_tag);
  assign mine  = (upd.idx == idx);

  always_comb begin
    scan_nxt = scan_in;
    if (!scan_in.hit && (valid_r || pend_r) && match) begin
      scan_nxt.hit       = 1'b1;
      scan_nxt.hit_valid = valid_r;
      scan_nxt.hit_idx   = idx;
    end
    if (!scan_in.free && !valid_r && !pend_r) begin
      scan_nxt.free     = 1'b1;
      scan_nxt.free_idx = idx;
    end
    if (!pend_r && (!scan_in.lru || stamp_r < scan_in.lru_stamp)) begin
      scan_nxt.lru       = 1'b1;
      scan_nxt.lru_idx   = idx;
      scan_nxt.lru_stamp = stamp_r;
      scan_nxt.lru_valid = valid_r;
    end
    if (sel_ok && sel_idx == idx && pend_r && match) begin
      scan_nxt.done_match = 1'b1;
    end
  end

  always_comb begin
    tag_nxt   = tag_r;
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    stamp_nxt = stamp_r;
    if (upd.clear) begin
      tag_nxt   = '0;
      valid_nxt = 1'b0;
      stamp_nxt = '0;
    end else if (mine && upd.alloc) begin
      tag_nxt   = req_tag;
      valid_nxt = 1'b0;
      pend_nxt  = 1'b1;
      stamp_nxt = upd.stamp;
    end else if (mine && upd.touch) begin
      stamp_nxt = upd.stamp;
    end else if (mine && upd.done) begin
      valid_nxt = upd.ok;
      pend_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
      stamp_r <= '0;
      scan_r  <= '0;
    end else begin
      tag_r   <= tag_nxt;
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      stamp_r <= stamp_nxt;
      scan_r  <= scan_nxt;
    end
  end

  assign scan_out = scan_r;

endmodule

// ===== rtl/tile_cache_lru_pending_unit.sv =====
`timescale 1ns / 1ps
// A result word is registered once its input word is taken, the scan word
// has walked the row of entry cells one cell per cycle (SCAN state) and the
// DECIDE state is reached, later if the output is stalled. in_stall is high
// outside IDLE, so no new word is taken until the last one has its result.
// Reset: synchronous, active low; clears all entries and the use counter.
// ----------------------------------------------------------------------------
// tile_cache_lru_pending_unit
// Fully associative tile tag store with LRU replacement and pending tracking.
// ----------------------------------------------------------------------------
module tile_cache_lru_pending_unit import tclp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [COORD_W-1:0]  in_column,
  input  logic [COORD_W-1:0]  in_row,
  input  logic [ZOOM_W-1:0]   in_zoom,
  input  logic                in_touch_on_hit,
  input  logic [SLOT_W-1:0]   in_slot_in,
  input  logic                in_download_ok,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot_out,
  output logic                out_evicted
);

  typedef enum logic [1:0] {IDLE, SCAN, DECIDE} state_t;

  state_t              state_r;
  logic [IDX_W-1:0]    cnt_r;
  logic [STAMP_W-1:0]  use_r, use_nxt;
  logic [CMD_W-1:0]    cmd_r;
  tag_t                tag_r;
  logic                touch_r;
  logic [IDX_W-1:0]    sel_r;
  logic                sel_ok_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                ok_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_out_r, slot_nxt;
  logic                evicted_r, evicted_nxt;
  logic                fire;
  upd_t                upd;
  scan_t               chain [NUM_SLOTS+1];
  scan_t               last;

  assign chain[0] = '0;
  assign last     = chain[NUM_SLOTS];
  assign fire     = (state_r == DECIDE) && !(out_valid_r && out_stall);

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    tclp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (IDX_W'(g)),
      .req_tag  (tag_r),
      .sel_idx  (sel_r),
      .sel_ok   (sel_ok_r),
      .upd      (upd),
      .scan_in  (chain[g]),
      .scan_out (chain[g+1])
    );
  end

  always_comb begin
    upd         = '0;
    upd.stamp   = use_r;
    upd.ok      = ok_r;
    use_nxt     = use_r;
    status_nxt  = ST_CLEARED;
    slot_nxt    = '0;
    evicted_nxt = 1'b0;
    case (cmd_r)
      CMD_REQUEST: begin
        if (last.hit) begin
          slot_nxt = SLOT_W'(last.hit_idx);
          if (last.hit_valid) begin
            status_nxt = ST_VALID_HIT;
            if (touch_r) begin
              upd.touch = fire;
              upd.idx   = last.hit_idx;
              use_nxt   = use_r + 1'b1;
            end
          end else begin
            status_nxt = ST_PENDING_HIT;
          end
        end else if (last.free || last.lru) begin
          status_nxt = ST_ALLOCATED;
          upd.alloc  = fire;
          use_nxt    = use_r + 1'b1;
          if (last.free) begin
            upd.idx = last.free_idx;
          end else begin
            upd.idx     = last.lru_idx;
            evicted_nxt = last.lru_valid;
          end
          slot_nxt = SLOT_W'(upd.idx);
        end else begin
          status_nxt = ST_NO_SLOT;
        end
      end
      CMD_DONE: begin
        if (last.done_match) begin
          status_nxt = ST_COMPLETED;
          slot_nxt   = slot_r;
          upd.done   = fire;
          upd.idx    = sel_r;
        end else begin
          status_nxt = ST_STALE;
        end
      end
      default: begin
        upd.clear = fire;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      use_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_valid) begin
            state_r  <= SCAN;
            cnt_r    <= '0;
            cmd_r    <= in_command;
            tag_r    <= '{col: in_column, row: in_row, zoom: in_zoom};
            touch_r  <= in_touch_on_hit;
            sel_r    <= IDX_W'(in_slot_in);
            sel_ok_r <= (32'(in_slot_in) < NUM_SLOTS);
            slot_r   <= in_slot_in;
            ok_r     <= in_download_ok;
          end
        end
        SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IDX_W'(NUM_SLOTS - 1)) begin
            state_r <= DECIDE;
          end
        end
        DECIDE: begin
          if (fire) begin
            state_r     <= IDLE;
            use_r       <= use_nxt;
            out_valid_r <= 1'b1;
            status_r    <= status_nxt;
            slot_out_r  <= slot_nxt;
            evicted_r   <= evicted_nxt;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_slot_out = slot_out_r;
  assign out_evicted  = evicted_r;

endmodule

// ===== rtl/tclp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_checker
// Port-level checks for the tile tag store.
// ----------------------------------------------------------------------------
module tclp_checker import tclp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic [SLOT_W-1:0]   out_slot_out,
  input logic                out_evicted
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_slot_out))
    else $error("result word changed while stalled");

  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_status == ST_ALLOCATED)
    else $error("eviction flagged without allocation");

  a_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_SLOT || out_status == ST_STALE ||
                  out_status == ST_CLEARED) |-> out_slot_out == '0)
    else $error("slot reported for a slotless result");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("new word taken during scan");

endmodule

bind tile_cache_lru_pending_unit tclp_checker u_tclp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_status   (out_status),
  .out_slot_out (out_slot_out),
  .out_evicted  (out_evicted)
);
